FILE: sv/firmware_update_receiver_top_macros.svh
// Assertion macros for the firmware update receiver.
`ifndef FIRMWARE_UPDATE_RECEIVER_TOP_MACROS_SVH
`define FIRMWARE_UPDATE_RECEIVER_TOP_MACROS_SVH
`define FUR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FUR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: sv/fur_pkg.sv
// Types and constants for the firmware update receiver.
package fur_pkg;
    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] header_magic;
        logic [31:0] image_length;
        logic [31:0] image_checksum;
        logic [7:0]  payload_byte;
        logic [15:0] packet_length;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] flash_address;
        logic [31:0] write_value;
        logic        accepted;
        logic [6:0]  percent_done;
        logic [2:0]  phase_now;
        logic        final_result;
    } t_out_item;

    localparam logic [1:0] OP_BEGIN  = 2'd0;
    localparam logic [1:0] OP_DATA   = 2'd1;
    localparam logic [1:0] OP_END    = 2'd2;
    localparam logic [1:0] OP_CANCEL = 2'd3;

    localparam logic [2:0] K_ACK   = 3'd0;
    localparam logic [2:0] K_ERASE = 3'd1;
    localparam logic [2:0] K_WRITE = 3'd2;
    localparam logic [2:0] K_PROG  = 3'd3;
    localparam logic [2:0] K_BOOT  = 3'd4;
    localparam logic [2:0] K_RESET = 3'd5;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_RECV    = 3'd1;
    localparam logic [2:0] PH_INSTALL = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;
    localparam logic [2:0] PH_ERR     = 3'd5;

    localparam logic [2:0] REG_MAGIC = 3'd0;
    localparam logic [2:0] REG_BASE  = 3'd1;
    localparam logic [2:0] REG_PART  = 3'd2;
    localparam logic [2:0] REG_MAXPK = 3'd3;
    localparam logic [2:0] REG_BOOTA = 3'd4;

    localparam logic [31:0] BOOT_FLAG_WORD = 32'hDEADBEEF;
    localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
endpackage

FILE: sv/firmware_update_receiver_top.sv
// Firmware update receiver: command decode, bit-serial CRC-32 and division, result register.
//
// One command is taken at a time. A data byte goes through the accept, the bit-serial CRC
// update, the count update, the packet-end check and the write result. A packet end that
// is not dropped and does not fail the final checksum adds the restoring progress division
// (one quotient bit a cycle) and the progress result. An accepted begin gives one erase
// request per sector and an acknowledge, end gives a boot and a reset result, and cancel
// and ignored commands give none. Each result waits until the output register is empty,
// so a stalled sink holds the sequence. The next command is accepted while the last
// result of the previous one still waits in the output register.
module firmware_update_receiver_top #(
    parameter int MAX_SECTORS  = 32,
    parameter int SECTOR_BYTES = 131072
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  fur_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output fur_pkg::t_out_item o_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import fur_pkg::*;
    `include "firmware_update_receiver_top_macros.svh"

    localparam int SW = $clog2(MAX_SECTORS + 1);
    localparam int SB = $clog2(SECTOR_BYTES);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ERASE = 4'd1;
    localparam logic [3:0] S_ACK   = 4'd2;
    localparam logic [3:0] S_CRC   = 4'd3;
    localparam logic [3:0] S_WR    = 4'd4;
    localparam logic [3:0] S_PEND  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_PROG  = 4'd7;
    localparam logic [3:0] S_BOOT  = 4'd8;
    localparam logic [3:0] S_RST   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_NACK  = 4'd11;

    logic [31:0] r_magic, r_base, r_boota;
    logic [22:0] r_part;
    logic [12:0] r_maxpk;
    logic [2:0]  r_phase;
    logic [22:0] r_rcv;
    logic [31:0] r_total, r_crc, r_tcrc;
    logic [15:0] r_ppos;
    logic        r_drop;

    logic [3:0]  r_st;
    logic [3:0]  r_ret;
    t_in_item    r_in;
    logic [SW-1:0] r_sec, r_nsec;
    logic [31:0] r_eaddr;
    logic [31:0] r_c;
    logic [2:0]  r_bit;
    logic [5:0]  r_dstep;
    logic [38:0] r_num;
    logic [32:0] r_rem;
    logic        r_wr_pending;
    logic [22:0] r_wr_cnt;
    t_out_item   r_out;
    logic        r_ov;

    logic        w_take;
    logic [SW-1:0] w_nsec;
    logic        w_last;
    logic [31:0] w_cb;
    logic [32:0] w_sh;
    logic [38:0] w_prod;

    assign o_ready     = (r_st == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ov;
    assign o_data      = r_out;
    assign w_take      = i_valid && o_ready;

    always_comb begin
        logic [22:0] q;
        q = r_part >> SB;
        if ((r_part & 23'((SECTOR_BYTES - 1))) != 23'd0) q = q + 23'd1;
        if (q > 23'(MAX_SECTORS)) q = 23'(MAX_SECTORS);
        w_nsec = SW'(q);
    end

    assign w_last = !(({16'd0, r_ppos} + 32'd1) < {16'd0, r_in.packet_length});
    assign w_cb   = r_c[0] ? ((r_c >> 1) ^ CRC_POLY) : (r_c >> 1);
    assign w_sh   = {r_rem[31:0], r_num[38]};
    assign w_prod = 39'({r_rcv, 6'd0}) + 39'({r_rcv, 5'd0}) + 39'({r_rcv, 2'd0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= '0; r_base <= '0; r_boota <= 32'd512;
            r_part <= 23'd1048576; r_maxpk <= 13'd256;
            r_phase <= PH_IDLE; r_rcv <= '0; r_total <= '0;
            r_crc <= '0; r_tcrc <= '0; r_ppos <= '0; r_drop <= 1'b0;
            r_st <= S_IDLE; r_ov <= 1'b0; r_wr_pending <= 1'b0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_MAGIC: r_magic <= i_cfg_data;
                    REG_BASE:  r_base  <= i_cfg_data;
                    REG_PART:  r_part  <= i_cfg_data[22:0];
                    REG_MAXPK: r_maxpk <= i_cfg_data[12:0];
                    REG_BOOTA: r_boota <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_st)
                S_IDLE: if (w_take) begin
                    r_in <= i_data;
                    unique case (i_data.operation)
                        OP_BEGIN: begin
                            if (i_data.header_magic != r_magic
                                || i_data.image_length > {9'd0, r_part}) begin
                                r_st <= S_NACK;
                            end else begin
                                r_nsec <= w_nsec; r_sec <= '0; r_eaddr <= r_base;
                                r_st <= (w_nsec == '0) ? S_ACK : S_ERASE;
                            end
                        end
                        OP_DATA: begin
                            if (r_phase == PH_RECV) begin
                                if (r_ppos == '0 && i_data.packet_length != '0
                                    && i_data.packet_length <= 16'(r_maxpk)
                                    && ({8'd0, r_rcv} + {15'd0, i_data.packet_length}
                                        > {8'd0, r_part})) begin
                                    r_phase <= PH_ERR;
                                end else begin
                                    if (r_ppos == '0 && i_data.packet_length != '0
                                        && i_data.packet_length > 16'(r_maxpk))
                                        r_drop <= 1'b1;
                                    r_st <= S_CRC;
                                    r_c <= ~r_crc ^ {24'd0, i_data.payload_byte};
                                    r_bit <= '0;
                                end
                            end
                        end
                        OP_END: if (r_phase == PH_DONE) begin
                            r_phase <= PH_INSTALL; r_st <= S_BOOT;
                        end
                        default: begin
                            r_phase <= PH_IDLE; r_rcv <= '0; r_total <= '0;
                            r_ppos <= '0; r_drop <= 1'b0;
                        end
                    endcase
                end
                S_NACK: if (!r_ov) begin
                    r_out <= '{K_ACK, 32'd0, 32'd0, 1'b0, 7'd0, r_phase, 1'b1};
                    r_ov <= 1'b1; r_st <= S_IDLE;
                end
                S_ERASE: if (!r_ov) begin
                    r_out <= '{K_ERASE, r_eaddr, 32'd0, 1'b0, 7'd0, PH_RECV, 1'b0};
                    r_ov <= 1'b1;
                    r_eaddr <= r_eaddr + 32'(SECTOR_BYTES);
                    r_sec <= r_sec + SW'(1);
                    if (r_sec + SW'(1) == r_nsec) r_st <= S_ACK;
                end
                S_ACK: if (!r_ov) begin
                    r_out <= '{K_ACK, 32'd0, 32'd0, 1'b1, 7'd0, PH_RECV, 1'b1};
                    r_ov <= 1'b1; r_st <= S_IDLE;
                    r_rcv <= '0; r_total <= r_in.image_length; r_crc <= '0;
                    r_tcrc <= r_in.image_checksum; r_ppos <= '0; r_drop <= 1'b0;
                    r_phase <= PH_RECV;
                end
                S_CRC: begin
                    r_bit <= r_bit + 3'd1;
                    if (r_bit == 3'd7) r_st <= S_WR;
                    if (r_in.packet_length != '0 && !r_drop) r_c <= w_cb;
                end
                S_WR: begin
                    r_wr_pending <= (r_in.packet_length != '0) && !r_drop;
                    if (r_in.packet_length != '0 && !r_drop) begin
                        r_crc <= ~r_c;
                        r_wr_cnt <= r_rcv;
                        r_rcv <= r_rcv + 23'd1;
                    end
                    r_st <= S_PEND;
                end
                S_PEND: begin
                    if (r_in.packet_length != '0 && !w_last) begin
                        r_ppos <= r_ppos + 16'd1;
                        r_ret <= S_IDLE;
                    end else begin
                        r_ppos <= '0;
                        if (r_drop) begin
                            r_drop <= 1'b0; r_ret <= S_IDLE;
                        end else if ({9'd0, r_rcv} >= r_total) begin
                            if (r_crc != r_tcrc) begin
                                r_phase <= PH_ERR; r_ret <= S_IDLE;
                            end else begin
                                r_phase <= PH_DONE; r_ret <= S_DIV;
                            end
                        end else begin
                            r_ret <= S_DIV;
                        end
                    end
                    r_num <= w_prod; r_rem <= '0; r_dstep <= '0;
                    r_st <= S_OUT;
                end
                S_OUT: if (!r_ov) begin
                    if (r_wr_pending) begin
                        r_out <= '{K_WRITE, r_base + {9'd0, r_wr_cnt},
                                   {24'd0, r_in.payload_byte}, 1'b0, 7'd0,
                                   r_phase, (r_ret == S_IDLE)};
                        r_ov <= 1'b1; r_wr_pending <= 1'b0;
                    end
                    r_st <= r_ret;
                end
                S_DIV: begin
                    if (r_total == '0) begin
                        r_num <= '0; r_st <= S_PROG;
                    end else begin
                        if (w_sh >= {1'b0, r_total}) begin
                            r_rem <= w_sh - {1'b0, r_total};
                            r_num <= {r_num[37:0], 1'b1};
                        end else begin
                            r_rem <= w_sh;
                            r_num <= {r_num[37:0], 1'b0};
                        end
                        r_dstep <= r_dstep + 6'd1;
                        if (r_dstep == 6'd38) r_st <= S_PROG;
                    end
                end
                S_PROG: if (!r_ov) begin
                    r_out <= '{K_PROG, 32'd0, 32'd0, 1'b0,
                               (r_num > 39'd100) ? 7'd100 : r_num[6:0], r_phase, 1'b1};
                    r_ov <= 1'b1; r_st <= S_IDLE;
                end
                S_BOOT: if (!r_ov) begin
                    r_out <= '{K_BOOT, r_boota, BOOT_FLAG_WORD, 1'b0, 7'd0, PH_INSTALL, 1'b0};
                    r_ov <= 1'b1; r_st <= S_RST;
                end
                S_RST: if (!r_ov) begin
                    r_out <= '{K_RESET, 32'd0, 32'd0, 1'b0, 7'd0, PH_INSTALL, 1'b1};
                    r_ov <= 1'b1; r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `FUR_ASSERT_IMPL(a_busy_no_take, i_clk, i_rst_n, r_st != S_IDLE, !o_ready,
        "input accepted while busy")
    `FUR_ASSERT_NEXT(a_crc_len, i_clk, i_rst_n, r_st == S_CRC && r_bit != 3'd7,
        r_st == S_CRC, "CRC loop left early")
    `FUR_ASSERT_IMPL(a_prog_range, i_clk, i_rst_n, o_valid && o_data.kind == K_PROG,
        o_data.percent_done <= 7'd100, "progress above 100")
endmodule

FILE: verif/firmware_update_receiver_top_tb.sv
// Self-checking testbench for the firmware update receiver: directed and random update sessions.
module firmware_update_receiver_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fur_pkg::*;

    localparam int SECTORS_MAX = 32;
    localparam int SECTOR_SIZE = 131072;

    class update_scoreboard;
        logic [31:0] magic_reg, base_reg, boot_reg;
        logic [22:0] part_reg;
        logic [12:0] maxpk_reg;
        logic [2:0]  phase;
        logic [22:0] rcvd;
        logic [31:0] total, crc, want_crc;
        logic [15:0] pkt_pos;
        bit          dropping;
        t_out_item   results_due[$];
        int          errors;

        function new();
            magic_reg = 0; base_reg = 0; part_reg = 23'd1048576;
            maxpk_reg = 13'd256; boot_reg = 32'd512;
            phase = PH_IDLE; rcvd = 0; total = 0; crc = 0; want_crc = 0;
            pkt_pos = 0; dropping = 0; errors = 0;
        endfunction

        static function logic [31:0] crc_step(logic [31:0] c_in, logic [7:0] b);
            logic [31:0] c;
            c = ~c_in ^ {24'd0, b};
            for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            return ~c;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_MAGIC: magic_reg = v;
                REG_BASE:  base_reg = v;
                REG_PART:  part_reg = v[22:0];
                REG_MAXPK: maxpk_reg = v[12:0];
                REG_BOOTA: boot_reg = v;
                default: ;
            endcase
        endfunction

        function t_out_item mk(logic [2:0] k, logic [31:0] a, logic [31:0] v,
                               logic acc, logic [6:0] pct);
            t_out_item r;
            r = '0;
            r.kind = k; r.flash_address = a; r.write_value = v;
            r.accepted = acc; r.percent_done = pct;
            return r;
        endfunction

        function logic [6:0] pct_now();
            logic [63:0] p;
            if (total == 0) return 0;
            p = (64'(rcvd) * 100) / total;
            return (p > 100) ? 7'd100 : p[6:0];
        endfunction

        function void note_beat(t_in_item it);
            t_out_item tmp[$];
            int        secs;
            bit        done;
            done = 0;
            case (it.operation)
                OP_BEGIN: begin
                    if (it.header_magic != magic_reg || it.image_length > 32'(part_reg)) begin
                        tmp.push_back(mk(K_ACK, 0, 0, 0, 0));
                    end else begin
                        secs = (int'(part_reg) + SECTOR_SIZE - 1) / SECTOR_SIZE;
                        if (secs > SECTORS_MAX) secs = SECTORS_MAX;
                        for (int i = 0; i < secs; i++)
                            tmp.push_back(mk(K_ERASE, base_reg + 32'(i * SECTOR_SIZE), 0, 0, 0));
                        tmp.push_back(mk(K_ACK, 0, 0, 1, 0));
                        rcvd = 0; total = it.image_length; crc = 0;
                        want_crc = it.image_checksum; pkt_pos = 0; dropping = 0;
                        phase = PH_RECV;
                    end
                end
                OP_DATA: begin
                    if (phase != PH_RECV) done = 1;
                    if (!done && pkt_pos == 0 && it.packet_length != 0) begin
                        if (32'(it.packet_length) > 32'(maxpk_reg)) begin
                            dropping = 1;
                        end else if (32'(rcvd) + 32'(it.packet_length) > 32'(part_reg)) begin
                            phase = PH_ERR;
                            done = 1;
                        end
                    end
                    if (!done && it.packet_length != 0) begin
                        if (!dropping) begin
                            crc = crc_step(crc, it.payload_byte);
                            tmp.push_back(mk(K_WRITE, base_reg + 32'(rcvd),
                                             32'(it.payload_byte), 0, 0));
                            rcvd = rcvd + 1;
                        end
                        if (32'(pkt_pos) + 1 < 32'(it.packet_length)) begin
                            pkt_pos = pkt_pos + 1;
                            done = 1;
                        end
                    end
                    if (!done) begin
                        pkt_pos = 0;
                        if (dropping) begin
                            dropping = 0;
                        end else if (32'(rcvd) >= total && crc != want_crc) begin
                            phase = PH_ERR;
                        end else begin
                            if (32'(rcvd) >= total) phase = PH_DONE;
                            tmp.push_back(mk(K_PROG, 0, 0, 0, pct_now()));
                        end
                    end
                end
                OP_END: begin
                    if (phase == PH_DONE) begin
                        phase = PH_INSTALL;
                        tmp.push_back(mk(K_BOOT, boot_reg, BOOT_FLAG_WORD, 0, 0));
                        tmp.push_back(mk(K_RESET, 0, 0, 0, 0));
                    end
                end
                default: begin
                    phase = PH_IDLE; rcvd = 0; total = 0; pkt_pos = 0; dropping = 0;
                end
            endcase
            foreach (tmp[i]) begin
                tmp[i].phase_now = phase;
                tmp[i].final_result = (i == tmp.size() - 1);
                results_due.push_back(tmp[i]);
            end
        endfunction

        function void cmp(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a) begin
                $error("%s: expected %0h, got %0h", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (results_due.size() == 0) begin
                $error("unexpected result kind %0d", got.kind);
                errors++;
                return;
            end
            e = results_due.pop_front();
            cmp("kind", 32'(e.kind), 32'(got.kind));
            cmp("flash_address", e.flash_address, got.flash_address);
            cmp("write_value", e.write_value, got.write_value);
            cmp("accepted", 32'(e.accepted), 32'(got.accepted));
            cmp("percent_done", 32'(e.percent_done), 32'(got.percent_done));
            cmp("phase_now", 32'(e.phase_now), 32'(got.phase_now));
            cmp("final_result", 32'(e.final_result), 32'(got.final_result));
        endfunction
    endclass

    logic        i_clk, i_rst_n, i_valid, o_ready, o_valid, i_ready;
    logic        i_cfg_valid, o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    t_in_item    i_data;
    t_out_item   o_data;

    update_scoreboard sb = new();
    int  beats_sent;
    bit  calm;
    int  hold;

    firmware_update_receiver_top #(.MAX_SECTORS(SECTORS_MAX), .SECTOR_BYTES(SECTOR_SIZE)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial i_clk = 0;
    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    initial begin
        #5ms;
        $display("[firmware_update_receiver_top] ERROR");
        $finish;
    end

    // sink side: random back-pressure
    initial begin
        i_ready = 0;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0 && !calm) begin
                i_ready <= 0;
                hold--;
            end else begin
                i_ready <= 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_data);
            hold = $urandom_range(0, 8);
        end
    end

    task automatic send_beat(t_in_item it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1;
        i_data <= it;
        do @(posedge i_clk); while (!o_ready);
        sb.note_beat(it);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_op(logic [1:0] op, logic [31:0] mg, logic [31:0] len,
                           logic [31:0] ck, logic [7:0] b, logic [15:0] plen);
        t_in_item it;
        it.operation = op; it.header_magic = mg; it.image_length = len;
        it.image_checksum = ck; it.payload_byte = b; it.packet_length = plen;
        send_beat(it);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.results_due.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [31:0] v);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, v);
        @(negedge i_clk);
    endtask

    task automatic set_all(logic [31:0] mg, logic [31:0] base, logic [31:0] part,
                           logic [31:0] mp, logic [31:0] boot);
        drain();
        cfg_write(REG_MAGIC, mg);
        cfg_write(REG_BASE, base);
        cfg_write(REG_PART, part);
        cfg_write(REG_MAXPK, mp);
        cfg_write(REG_BOOTA, boot);
        i_cfg_valid <= 0;
    endtask

    // one update: begin, packets (some dropped or empty), end, and sometimes a cancel
    task automatic run_image(int len, bit good_crc);
        logic [7:0]  img[$];
        logic [31:0] c;
        int          pos, n, lim, r;
        c = 0;
        for (int i = 0; i < len; i++) begin
            img.push_back(8'($urandom_range(0, 255)));
            c = update_scoreboard::crc_step(c, img[i]);
        end
        if (!good_crc) c ^= $urandom_range(1, 32'hFFFF_FFFF);
        send_op(OP_BEGIN, sb.magic_reg, len, c, 8'($urandom), 16'($urandom));
        pos = 0;
        while (pos < len) begin
            r = $urandom_range(0, 11);
            if (r == 0 && sb.maxpk_reg < 16'hFFFF) begin
                send_op(OP_DATA, $urandom, $urandom, $urandom, 8'($urandom),
                        16'($urandom_range(int'(sb.maxpk_reg) + 1, 65535)));
                send_op(OP_DATA, $urandom, $urandom, $urandom, 8'($urandom), 16'd2);
            end else if (r == 1) begin
                send_op(OP_DATA, $urandom, $urandom, $urandom, 8'($urandom), 16'd0);
            end else begin
                lim = len - pos;
                if (lim > int'(sb.maxpk_reg)) lim = int'(sb.maxpk_reg);
                if (lim > 16) lim = 16;
                n = $urandom_range(1, lim);
                for (int i = 0; i < n; i++)
                    send_op(OP_DATA, $urandom, $urandom, $urandom, img[pos + i], 16'(n));
                pos += n;
            end
        end
        if (len == 0) send_op(OP_DATA, $urandom, $urandom, $urandom, 8'($urandom), 16'd0);
        send_op(OP_END, $urandom, $urandom, $urandom, 8'($urandom), 16'($urandom));
        if ($urandom_range(0, 3) == 0)
            send_op(OP_CANCEL, $urandom, $urandom, $urandom, 8'd0, 16'd0);
    endtask

    initial begin
        logic [31:0] part, mp;
        int          len;
        i_rst_n = 0; i_valid = 0; i_data = '0;
        i_cfg_valid = 0; i_cfg_index = 0; i_cfg_data = 0;
        beats_sent = 0; calm = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1;

        // directed
        send_op(OP_DATA, 0, 0, 0, 8'hFF, 16'hFFFF);
        send_op(OP_END, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, 16'd0);
        send_op(OP_BEGIN, 32'hFFFF_FFFF, 0, 0, 8'd0, 16'd0);
        send_op(OP_BEGIN, 0, 32'hFFFF_FFFF, 0, 8'd0, 16'd0);
        run_image(3, 1);
        set_all(32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'd4194304, 32'd4096, 32'hFFFF_FFFF);
        run_image(5, 0);
        set_all(32'h1234_5678, 0, 32'd16, 32'd1, 0);
        send_op(OP_BEGIN, 32'h1234_5678, 10, 0, 8'd0, 16'd0);
        send_op(OP_DATA, 0, 0, 0, 8'h00, 16'd1);
        send_op(OP_DATA, 0, 0, 0, 8'h55, 16'd20);
        set_all(32'h0, 32'h100, 32'd0, 32'd4096, 32'h40);
        run_image(0, 1);
        send_op(OP_DATA, 0, 0, 0, 8'hA5, 16'd1);
        send_op(OP_CANCEL, 0, 0, 0, 8'd0, 16'd0);
        set_all($urandom, $urandom, 32'd131073, 32'd8, $urandom);
        run_image(4, 1);
        drain();

        // random sessions
        while (beats_sent < 360) begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 4))
                    0: part = 0;
                    1: part = 64;
                    2: part = 4194304;
                    3: part = $urandom_range(1, 32) * SECTOR_SIZE;
                    default: part = $urandom_range(1, 4194304);
                endcase
                case ($urandom_range(0, 2))
                    0: mp = 1;
                    1: mp = 4096;
                    default: mp = $urandom_range(1, 24);
                endcase
                set_all($urandom, $urandom, part, mp, $urandom);
            end
            case ($urandom_range(0, 9))
                0: send_op(OP_BEGIN, $urandom, $urandom, $urandom, 8'($urandom),
                           16'($urandom));
                1: send_op(OP_BEGIN, sb.magic_reg, $urandom_range(32'h8000_0000, 32'hFFFF_FFFF),
                           $urandom, 8'($urandom), 16'($urandom));
                2: send_op(2'($urandom_range(1, 3)), $urandom, $urandom, $urandom,
                           8'($urandom), 16'($urandom));
                default: ;
            endcase
            len = $urandom_range(0, 24);
            if (len > int'(sb.part_reg)) len = int'(sb.part_reg);
            run_image(len, $urandom_range(0, 4) != 0);
        end

        drain();
        if (sb.results_due.size() == 0 && sb.errors == 0)
            $display("[firmware_update_receiver_top] OK");
        else
            $display("[firmware_update_receiver_top] ERROR");
        $finish;
    end
endmodule
